// ===== design/ardg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ardg_pkg;
   localparam int MaxSlots = 16;
   localparam int SlotW = 4;
   localparam int CordicSteps = 16;
   localparam int StepW = 5;
   localparam logic signed [47:0] S48Max = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] S48Min = -48'sh7FFF_FFFF_FFFF - 48'sd1;
   localparam logic signed [47:0] TwoPi = 48'sd105414357;
   localparam logic signed [47:0] Pi = 48'sd52707179;
   localparam logic signed [47:0] HalfPi = 48'sd26353589;
   localparam logic [29:0] GainInv = 30'd652032874;
   localparam logic [0:0] CSR_NORM = 1'b0;
   localparam logic [0:0] CSR_COUNT = 1'b1;

   function automatic logic signed [27:0] atan_lut(input logic [StepW-1:0] i);
      logic signed [27:0] r;
      case (i)
         5'd0: r = 28'sd13176795;
         5'd1: r = 28'sd7778716;
         5'd2: r = 28'sd4110060;
         5'd3: r = 28'sd2086331;
         5'd4: r = 28'sd1047214;
         5'd5: r = 28'sd524117;
         5'd6: r = 28'sd262123;
         5'd7: r = 28'sd131069;
         default: r = (i < 5'd24) ? (28'sd1 <<< (5'd24 - i)) : 28'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
      if (v > 50'(S48Max)) return S48Max;
      if (v < 50'(S48Min)) return S48Min;
      return v[47:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
      if (v > 50'sd32767) return 16'sh7FFF;
      if (v < -50'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction
endpackage
`default_nettype wire

// ===== design/ard_fourier_feature_gradient_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Ordinary term: accept and multiply x*w, then accumulate slot and phase.
// Last term: those same steps, then shifted 2*pi subtracts or adds that bring the phase
// into [0, 2*pi), a fold step, the CORDIC (16 rotations and the done step), then a
// multiply and a present step per emitted slot, where the present step stalls on rsp_tready.
// Input is not ready from acceptance until the term, or the last slot item, is done.
// Synchronous active-high reset: state, norm scale and count at reset values, phase and accumulators zero.
module ard_fourier_feature_gradient_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,  // feature, weight, sigma, slot, zero pad
   input  wire logic        req_tlast,  // last_term
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [135:0] rsp_tdata, // cos, sin, slot, grad_neg_sin, grad_cos, pad
   output logic             rsp_tlast,  // last_result
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_addr,
   input  wire logic [15:0] csr_wdata
);
   localparam logic [2:0] S_IDLE = 3'd0, S_ACC = 3'd1, S_MOD = 3'd2,
                          S_FOLD = 3'd3, S_CORD = 3'd4, S_MUL = 3'd5, S_OUT = 3'd6;
   logic [2:0] st_ff, st_in;
   logic [15:0] norm_ff;
   logic [4:0]  cnt_ff;
   logic signed [31:0] prod_ff, prod_in;
   logic [15:0] sig_ff;
   logic [3:0]  slot_ff;
   logic        last_ff;
   logic signed [47:0] acc_ff [ardg_pkg::MaxSlots];
   logic signed [47:0] ph_ff, ph_in;
   logic [4:0]  sh_ff, sh_in;
   logic [4:0]  k_ff, k_in;
   logic [4:0]  n_eff;
   logic signed [48:0] red;
   logic signed [27:0] ang;
   logic        fneg;
   logic        cstart, cdone;
   logic signed [15:0] c_v, s_v;
   logic signed [63:0] gs_ff, gc_ff;
   logic signed [47:0] sig_term;
   logic signed [47:0] cur_acc;

   // One CORDIC; started once the phase is folded.
   ardg_cordic u_cordic (
      .clock(clock), .reset(reset), .start(cstart), .angle(ang), .negate(fneg),
      .norm_scale(norm_ff), .done(cdone), .cos_out(c_v), .sin_out(s_v)
   );

   assign n_eff = (cnt_ff == 5'd0) ? 5'd1 : (cnt_ff > 5'd16 ? 5'd16 : cnt_ff);
   assign req_tready = (st_ff == S_IDLE);
   assign cur_acc = acc_ff[k_ff[3:0]];
   assign sig_term = 48'((64'(prod_ff) * $signed({1'b0, sig_ff})) >>> 12);
   // Shifted subtract of 2*pi: reduce magnitude toward [0,2pi).
   assign red = 49'(ph_ff) - (49'(ardg_pkg::TwoPi) <<< sh_ff);

   always_comb begin
      fneg = 1'b0;
      ang = 28'(ph_ff);
      if (ph_ff > ardg_pkg::Pi) begin
         if (ph_ff - ardg_pkg::TwoPi < -ardg_pkg::HalfPi) begin
            ang = 28'(ph_ff - ardg_pkg::TwoPi + ardg_pkg::Pi); fneg = 1'b1;
         end else ang = 28'(ph_ff - ardg_pkg::TwoPi);
      end else if (ph_ff > ardg_pkg::HalfPi) begin
         ang = 28'(ph_ff - ardg_pkg::Pi); fneg = 1'b1;
      end
   end

   always_comb begin
      st_in = st_ff; ph_in = ph_ff; sh_in = sh_ff; k_in = k_ff; prod_in = prod_ff;
      cstart = 1'b0;
      unique case (st_ff)
         S_IDLE: if (req_tvalid) begin
            prod_in = 32'($signed(req_tdata[15:0]) * $signed(req_tdata[31:16]));
            st_in = S_ACC;
         end
         S_ACC: begin
            ph_in = ardg_pkg::sat48(50'(ph_ff) + 50'(sig_term));
            if (last_ff) begin
               st_in = S_MOD; sh_in = 5'd21;
            end else st_in = S_IDLE;
         end
         S_MOD: begin
            // negative phase: first add 2pi multiples, else subtract
            if (ph_ff < 0) begin
               if (49'(ph_ff) + (49'(ardg_pkg::TwoPi) <<< sh_ff) < 0 || sh_ff == 5'd0)
                  ph_in = 48'(49'(ph_ff) + (49'(ardg_pkg::TwoPi) <<< sh_ff));
               else sh_in = sh_ff - 5'd1;
            end else begin
               if (red >= 0) ph_in = red[47:0];
               else if (sh_ff == 5'd0) st_in = S_FOLD;
               else sh_in = sh_ff - 5'd1;
            end
         end
         S_FOLD: begin
            cstart = 1'b1; st_in = S_CORD; k_in = '0;
         end
         S_CORD: if (cdone) st_in = S_MUL;
         S_MUL: st_in = S_OUT;
         S_OUT: if (rsp_tready) begin
            k_in = k_ff + 5'd1;
            st_in = (k_ff + 5'd1 == n_eff) ? S_IDLE : S_MUL;
            if (k_ff + 5'd1 == n_eff) ph_in = '0;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in; sh_ff <= sh_in; k_ff <= k_in;
      if (st_ff == S_IDLE && req_tvalid) begin
         sig_ff <= req_tdata[47:32]; slot_ff <= req_tdata[51:48]; last_ff <= req_tlast;
      end
      if (st_ff == S_MUL) begin
         gs_ff <= 64'(cur_acc) * 64'(s_v);
         gc_ff <= 64'(cur_acc) * 64'(c_v);
      end
      if (reset) begin
         st_ff <= S_IDLE; ph_ff <= '0; norm_ff <= 16'd32768; cnt_ff <= 5'd1;
         for (int j = 0; j < ardg_pkg::MaxSlots; j++) acc_ff[j] <= '0;
      end else begin
         st_ff <= st_in; ph_ff <= ph_in;
         if (csr_we && csr_addr == ardg_pkg::CSR_NORM) norm_ff <= csr_wdata;
         if (csr_we && csr_addr == ardg_pkg::CSR_COUNT) cnt_ff <= csr_wdata[4:0];
         if (st_ff == S_ACC)
            acc_ff[slot_ff] <= ardg_pkg::sat48(50'(acc_ff[slot_ff]) + 50'(prod_ff));
         // clear all slots after the last result goes out
         if (st_ff == S_OUT && rsp_tready && k_ff + 5'd1 == n_eff)
            for (int j = 0; j < ardg_pkg::MaxSlots; j++) acc_ff[j] <= '0;
      end
   end

   logic signed [47:0] gns, gc;
   always_comb begin
      gns = ardg_pkg::sat48(50'((-gs_ff) >>> 14));
      gc  = ardg_pkg::sat48(50'(gc_ff >>> 14));
      if (((-gs_ff) >>> 14) > 64'(ardg_pkg::S48Max)) gns = ardg_pkg::S48Max;
      if (((-gs_ff) >>> 14) < 64'(ardg_pkg::S48Min)) gns = ardg_pkg::S48Min;
      if ((gc_ff >>> 14) > 64'(ardg_pkg::S48Max)) gc = ardg_pkg::S48Max;
      if ((gc_ff >>> 14) < 64'(ardg_pkg::S48Min)) gc = ardg_pkg::S48Min;
   end

   assign rsp_tvalid = (st_ff == S_OUT);
   assign rsp_tlast = (k_ff + 5'd1 == n_eff);
   assign rsp_tdata = {4'd0, gc, gns, k_ff[3:0], s_v, c_v};

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("ready while emitting");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> k_ff < n_eff) else $error("slot index past count");
endmodule
`default_nettype wire

// ===== design/ardg_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Iterative rotation CORDIC: one micro-rotation per cycle, phase already in +-pi/2.
module ardg_cordic (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [27:0] angle,
   input  wire logic               negate,
   input  wire logic [15:0]        norm_scale,
   output logic                    done,
   output logic signed [15:0]      cos_out,
   output logic signed [15:0]      sin_out
);
   logic signed [49:0] x_ff, x_in, y_ff, y_in;
   logic signed [27:0] z_ff, z_in;
   logic [ardg_pkg::StepW-1:0] i_ff, i_in;
   logic busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic signed [49:0] xs, ys, xf, yf;

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; i_in = i_ff;
      busy_in = busy_ff; neg_in = neg_ff; done_in = 1'b0;
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      if (start) begin
         x_in = 50'($signed({1'b0, 46'(ardg_pkg::GainInv) * 46'(norm_scale)}));
         y_in = '0; z_in = angle; i_in = '0; busy_in = 1'b1; neg_in = negate;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - ardg_pkg::atan_lut(i_ff);
         end else begin
            x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + ardg_pkg::atan_lut(i_ff);
         end
         i_in = i_ff + 1'b1;
         if (i_ff == 5'(ardg_pkg::CordicSteps - 1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; i_ff <= i_in; neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign xf = neg_ff ? -x_ff : x_ff;
   assign yf = neg_ff ? -y_ff : y_ff;
   assign cos_out = ardg_pkg::sat16((xf + (50'sd1 <<< 30)) >>> 31);
   assign sin_out = ardg_pkg::sat16((yf + (50'sd1 <<< 30)) >>> 31);
   assign done = done_ff;
endmodule
`default_nettype wire
